>>> sv/gtrst_pkg.sv
// shared types and constants for the generation tagged result slot table
package gtrst_pkg;

    localparam int HANDLE_W = 64;
    localparam int LEN_W = 32;
    localparam int ID_W = 32;

    typedef enum logic {
        OP_STORE    = 1'b0,
        OP_RETRIEVE = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STORE,
        ST_SWEEP,
        ST_EVICT,
        ST_MOD,
        ST_CHECK
    } t_state;

    // one slot row as held in the slot memory, handle in the lowest bits
    typedef struct packed {
        logic [ID_W-1:0]     prev_id;
        logic [ID_W-1:0]     cur_id;
        logic [LEN_W-1:0]    len;
        logic [HANDLE_W-1:0] handle;
    } t_row;

    // input item payload, buffer_handle in the lowest bits
    typedef struct packed {
        logic [LEN_W-1:0]    size_limit;
        logic                keep_if_larger;
        logic                keep_entry;
        logic [ID_W-1:0]     lookup_id;
        logic [LEN_W-1:0]    buffer_length;
        logic [HANDLE_W-1:0] buffer_handle;
    } t_in_data;

    // result item payload, assigned_id in the lowest bits
    typedef struct packed {
        logic [HANDLE_W-1:0] evicted_handle;
        logic                evicted;
        logic                entry_kept;
        logic [LEN_W-1:0]    found_length;
        logic [HANDLE_W-1:0] found_handle;
        logic                hit;
        logic [ID_W-1:0]     assigned_id;
    } t_result;

    localparam int IN_W = $bits(t_in_data);
    localparam int IN_DATA_W = ((IN_W + 7) / 8) * 8;
    localparam int RES_W = $bits(t_result);
    localparam int OUT_DATA_W = ((RES_W + 7) / 8) * 8;

endpackage

>>> sv/gtrst_ram.sv
// generic single write port ram with registered read
module gtrst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic                                      i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/gtrst_scan.sv
// round-robin search for the first free slot from the scan start
module gtrst_scan #(
    parameter int SLOT_COUNT = 32
) (
    input  logic [SLOT_COUNT-1:0]                                  i_busy,
    input  logic [((SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1)-1:0] i_start,
    output logic                                                   o_found,
    output logic [((SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1)-1:0] o_pos
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [IDX_W:0] N_EXT = (IDX_W + 1)'(SLOT_COUNT);

    always_comb begin
        logic [IDX_W:0]   sum;
        logic [IDX_W-1:0] idx;
        o_found = 1'b0;
        o_pos = i_start;
        // walk from the far end so the nearest free slot wins
        for (int j = SLOT_COUNT - 1; j >= 0; j--) begin
            sum = (IDX_W + 1)'(i_start) + (IDX_W + 1)'(j);
            idx = (sum >= N_EXT) ? IDX_W'(sum - N_EXT) : IDX_W'(sum);
            if (!i_busy[idx]) begin
                o_found = 1'b1;
                o_pos = idx;
            end
        end
    end

endmodule

>>> sv/gtrst_idmod.sv
// id modulo slot count by reciprocal multiply and one correction step
module gtrst_idmod #(
    parameter int SLOT_COUNT = 32
) (
    input  logic                                                   i_clk,
    input  logic                                                   i_rst_n,
    input  logic                                                   i_start,
    input  logic [gtrst_pkg::ID_W-1:0]                             i_id,
    output logic                                                   o_done,
    output logic [((SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1)-1:0] o_rem
);

    import gtrst_pkg::*;

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [ID_W-1:0] RECIP = ID_W'(64'h1_0000_0000 / 64'(SLOT_COUNT));
    localparam logic [IDX_W:0] N_EXT = (IDX_W + 1)'(SLOT_COUNT);

    logic                 r_v1;
    logic                 r_v2;
    logic [ID_W-1:0]      r_q;
    logic [IDX_W:0]       r_id_lo;
    logic [IDX_W:0]       r_diff;
    logic [2*ID_W-1:0]    prod;
    logic [IDX_W:0]       qn_lo;

    // quotient estimate is exact or one short, so the remainder is below twice the count
    assign prod = (2 * ID_W)'(i_id) * (2 * ID_W)'(RECIP);
    assign qn_lo = r_q[IDX_W:0] * N_EXT;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
        end
        if (i_start) begin
            r_q <= prod[2*ID_W-1:ID_W];
            r_id_lo <= i_id[IDX_W:0];
        end
        if (r_v1) begin
            r_diff <= r_id_lo - qn_lo;
        end
    end

    assign o_done = r_v2;
    assign o_rem = (r_diff >= N_EXT) ? IDX_W'(r_diff - N_EXT) : IDX_W'(r_diff);

endmodule

>>> sv/generation_tagged_result_slot_table.sv
// slot table of result buffers with generation tagged ids
//
//  channel | direction | payload
//  s_axis  | in        | tuser: op; tdata: handle, length, lookup id, keep flags, size limit
//  m_axis  | out       | tdata: assigned id, hit, found handle/length, kept, evicted, handle
//
// store to a free slot: slot memory read of the previous id, then write back
// store to a full table: one slot memory read per slot for the smallest id search
// retrieve: reduce the id modulo the slot count, then one memory read, then one check
// reset needs no clearing pass: per-row valid flops make an unwritten row read as its
//   reset value; a stalled result holds the block in its last state until the output frees
module generation_tagged_result_slot_table #(
    parameter int SLOT_COUNT = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // buffer_handle, buffer_length, lookup_id, keep_entry, keep_if_larger, size_limit
    input  logic [gtrst_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // op
    input  logic                                 s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // assigned_id, hit, found_handle, found_length, entry_kept, evicted, evicted_handle
    output logic [gtrst_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

    import gtrst_pkg::*;

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int ROW_W = $bits(t_row);
    localparam logic [ID_W-1:0] SLOT_INC = ID_W'(SLOT_COUNT);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);
    localparam logic [IDX_W:0] CNT_N = (IDX_W + 1)'(SLOT_COUNT);

    function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] a);
        return (a == LAST_IDX) ? '0 : a + 1'b1;
    endfunction

    t_state               r_state, n_state;
    logic [HANDLE_W-1:0]  r_handle, n_handle;
    logic [LEN_W-1:0]     r_len, n_len;
    logic [ID_W-1:0]      r_id, n_id;
    logic                 r_keep, n_keep;
    logic                 r_keep_big, n_keep_big;
    logic [LEN_W-1:0]     r_limit, n_limit;
    logic [IDX_W-1:0]     r_scan, n_scan;
    logic [SLOT_COUNT-1:0] r_busy, n_busy;
    logic [SLOT_COUNT-1:0] r_row_vld, n_row_vld;
    logic [IDX_W-1:0]     r_rd_addr, n_rd_addr;
    logic [IDX_W:0]       r_cnt, n_cnt;
    logic                 r_have, n_have;
    logic [IDX_W-1:0]     r_vic_idx, n_vic_idx;
    t_row                 r_vic_row, n_vic_row;
    logic                 r_m_valid, n_m_valid;
    t_result              r_m_data, n_m_data;

    t_in_data             in_data;
    logic                 in_acc;
    logic                 out_free;
    logic                 free_found;
    logic [IDX_W-1:0]     free_pos;
    logic                 mod_start;
    logic                 mod_done;
    logic [IDX_W-1:0]     mod_rem;
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    t_row                 ram_wdata;
    logic                 ram_re;
    logic [IDX_W-1:0]     ram_raddr;
    logic [ROW_W-1:0]     ram_rdata;
    t_row                 rd_row;

    assign in_data = t_in_data'(s_axis_tdata[IN_W-1:0]);
    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_m_valid || m_axis_tready;

    gtrst_scan #(
        .SLOT_COUNT(SLOT_COUNT)
    ) u_scan (
        .i_busy  (r_busy),
        .i_start (r_scan),
        .o_found (free_found),
        .o_pos   (free_pos)
    );

    gtrst_idmod #(
        .SLOT_COUNT(SLOT_COUNT)
    ) u_idmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mod_start),
        .i_id    (in_data.lookup_id),
        .o_done  (mod_done),
        .o_rem   (mod_rem)
    );

    gtrst_ram #(
        .WIDTH(ROW_W),
        .DEPTH(SLOT_COUNT)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // a row never written reads as its reset value
    always_comb begin
        rd_row = t_row'(ram_rdata);
        if (!r_row_vld[r_rd_addr]) begin
            rd_row = '0;
            rd_row.prev_id = ID_W'(r_rd_addr);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (t_op'(s_axis_tuser) == OP_STORE) begin
                        n_state = free_found ? ST_STORE : ST_SWEEP;
                    end else begin
                        n_state = ST_MOD;
                    end
                end
            end
            ST_STORE: begin
                if (out_free) n_state = ST_IDLE;
            end
            ST_SWEEP: begin
                if (r_cnt == CNT_N) n_state = ST_EVICT;
            end
            ST_EVICT: begin
                if (out_free) n_state = ST_IDLE;
            end
            ST_MOD: begin
                if (mod_done) n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        logic [ID_W-1:0] new_id;
        logic            take;
        logic            hit;
        logic            release_slot;
        n_handle = r_handle;
        n_len = r_len;
        n_id = r_id;
        n_keep = r_keep;
        n_keep_big = r_keep_big;
        n_limit = r_limit;
        n_scan = r_scan;
        n_busy = r_busy;
        n_row_vld = r_row_vld;
        n_rd_addr = r_rd_addr;
        n_cnt = r_cnt;
        n_have = r_have;
        n_vic_idx = r_vic_idx;
        n_vic_row = r_vic_row;
        n_m_valid = r_m_valid && !m_axis_tready;
        n_m_data = r_m_data;
        mod_start = 1'b0;
        ram_re = 1'b0;
        ram_raddr = r_rd_addr;
        ram_we = 1'b0;
        ram_waddr = r_rd_addr;
        ram_wdata = rd_row;
        new_id = '0;
        take = 1'b0;
        hit = 1'b0;
        release_slot = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_handle = in_data.buffer_handle;
                    n_len = in_data.buffer_length;
                    n_id = in_data.lookup_id;
                    n_keep = in_data.keep_entry;
                    n_keep_big = in_data.keep_if_larger;
                    n_limit = in_data.size_limit;
                    if (t_op'(s_axis_tuser) == OP_STORE) begin
                        ram_re = 1'b1;
                        ram_raddr = free_found ? free_pos : r_scan;
                        n_rd_addr = ram_raddr;
                        n_cnt = (IDX_W + 1)'(1);
                        n_have = 1'b0;
                    end else begin
                        mod_start = 1'b1;
                    end
                end
            end
            ST_STORE: begin
                if (out_free) begin
                    new_id = rd_row.prev_id + SLOT_INC;
                    ram_we = 1'b1;
                    ram_waddr = r_rd_addr;
                    ram_wdata.prev_id = rd_row.prev_id;
                    ram_wdata.cur_id = new_id;
                    ram_wdata.len = r_len;
                    ram_wdata.handle = r_handle;
                    n_busy[r_rd_addr] = 1'b1;
                    n_row_vld[r_rd_addr] = 1'b1;
                    n_scan = next_idx(r_rd_addr);
                    n_m_data = '0;
                    n_m_data.assigned_id = new_id;
                    n_m_valid = 1'b1;
                end
            end
            ST_SWEEP: begin
                // first smallest id in scan order wins, so only a strictly smaller one replaces it
                take = !r_have || (rd_row.cur_id < r_vic_row.cur_id);
                if (take) begin
                    n_vic_row = rd_row;
                    n_vic_idx = r_rd_addr;
                end
                n_have = 1'b1;
                if (r_cnt != CNT_N) begin
                    ram_re = 1'b1;
                    ram_raddr = next_idx(r_rd_addr);
                    n_rd_addr = ram_raddr;
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_EVICT: begin
                if (out_free) begin
                    new_id = r_vic_row.cur_id + SLOT_INC;
                    ram_we = 1'b1;
                    ram_waddr = r_vic_idx;
                    ram_wdata.prev_id = r_vic_row.prev_id;
                    ram_wdata.cur_id = new_id;
                    ram_wdata.len = r_len;
                    ram_wdata.handle = r_handle;
                    n_row_vld[r_vic_idx] = 1'b1;
                    n_m_data = '0;
                    n_m_data.assigned_id = new_id;
                    n_m_data.evicted = (r_vic_row.handle != '0);
                    n_m_data.evicted_handle = r_vic_row.handle;
                    n_m_valid = 1'b1;
                end
            end
            ST_MOD: begin
                if (mod_done) begin
                    ram_re = 1'b1;
                    ram_raddr = mod_rem;
                    n_rd_addr = mod_rem;
                end
            end
            ST_CHECK: begin
                if (out_free) begin
                    hit = (rd_row.handle != '0) && (rd_row.cur_id == r_id);
                    release_slot = !r_keep && (!r_keep_big || (rd_row.len <= r_limit));
                    n_m_data = '0;
                    if (hit) begin
                        n_m_data.hit = 1'b1;
                        n_m_data.found_handle = rd_row.handle;
                        n_m_data.found_length = rd_row.len;
                        n_m_data.entry_kept = !release_slot;
                        if (release_slot) begin
                            ram_we = 1'b1;
                            ram_waddr = r_rd_addr;
                            ram_wdata = '0;
                            ram_wdata.prev_id = rd_row.cur_id;
                            n_busy[r_rd_addr] = 1'b0;
                            n_row_vld[r_rd_addr] = 1'b1;
                        end
                    end
                    n_m_valid = 1'b1;
                end
            end
            default: begin
                n_m_valid = r_m_valid && !m_axis_tready;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_scan <= '0;
            r_busy <= '0;
            r_row_vld <= '0;
            r_have <= 1'b0;
            r_cnt <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_scan <= n_scan;
            r_busy <= n_busy;
            r_row_vld <= n_row_vld;
            r_have <= n_have;
            r_cnt <= n_cnt;
            r_m_valid <= n_m_valid;
        end
        r_handle <= n_handle;
        r_len <= n_len;
        r_id <= n_id;
        r_keep <= n_keep;
        r_keep_big <= n_keep_big;
        r_limit <= n_limit;
        r_rd_addr <= n_rd_addr;
        r_vic_idx <= n_vic_idx;
        r_vic_row <= n_vic_row;
        r_m_data <= n_m_data;
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata = OUT_DATA_W'(r_m_data);

    a_store_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_STORE) |-> !r_busy[r_rd_addr])
        else $error("store writes a busy slot");

    a_sweep_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SWEEP) |-> (&r_busy))
        else $error("eviction sweep with a free slot");

    a_evict_has_victim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EVICT) |-> r_have)
        else $error("eviction without a victim");

    a_mod_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mod_done |-> (mod_rem <= LAST_IDX))
        else $error("id remainder out of range");

endmodule
